### rtl/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants for the positional array store with sort.
// ----------------------------------------------------------------------------
`default_nettype none

package pas_pkg;

  localparam int unsigned Capacity  = 32;
  localparam int unsigned ElemBits  = 32;
  localparam int unsigned AddrBits  = $clog2(Capacity);
  localparam int unsigned CountBits = $clog2(Capacity + 1);
  localparam int unsigned StackBits = 2 * AddrBits;

  typedef logic signed [ElemBits-1:0] elem_t;
  typedef logic [AddrBits-1:0]        addr_t;
  typedef logic [CountBits-1:0]       count_t;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_SORT   = 3'd2,
    MODE_ROR    = 3'd3,
    MODE_ROL    = 3'd4,
    MODE_READ   = 3'd5,
    MODE_FREQ   = 3'd6,
    MODE_NOP    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_OOB   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    addr_t lo;
    addr_t hi;
  } span_t;

endpackage

`default_nettype wire

### rtl/pas_cmd_if.sv
// ----------------------------------------------------------------------------
// pas_cmd_if
// Command channel: mode, value and position with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pas_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic signed [31:0] value;
  logic [5:0]  position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

`default_nettype wire

### rtl/pas_res_if.sv
// ----------------------------------------------------------------------------
// pas_res_if
// Result channel: status, element, tally and last with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pas_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] element;
  logic [5:0]  tally;
  logic        last;

  modport source (output valid, status, element, tally, last, input ready);
  modport sink   (input valid, status, element, tally, last, output ready);
endinterface

`default_nettype wire

### rtl/pas_ram.sv
// ----------------------------------------------------------------------------
// pas_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/positional_array_store_with_sort.sv
// ----------------------------------------------------------------------------
// positional_array_store_with_sort
// Positional array of signed elements with insert, delete, sort, rotate,
// read and run-length frequency commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transaction (mode, value, position);
//   res_o returns the results. Every command yields one result with
//   last set, except frequency, which yields one result per distinct value
//   and sets last on the final one.
//   All work runs through a small sequencer around one element RAM (one
//   write, one registered read per cycle) and a range stack RAM. cmd_i is
//   not ready while a command is in progress.
//   Steps: read issues the address, then takes the registered data;
//   insert/delete move one element at a time; rotate first reduces the
//   count modulo occupancy by repeated subtraction, then does single
//   steps; sort is an iterative Lomuto quicksort with the range stack,
//   slowest on already sorted elements; frequency sorts the store first,
//   then scans the elements and emits one result per run.
//   Results sit in an output register; when res_o stalls the sequencer
//   waits at the next result. Reset empties the store (count zero).
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_store_with_sort (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pas_cmd_if.sink    cmd_i,
  pas_res_if.source  res_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_EMIT,
    S_INS_CHK, S_INS_WR,
    S_DEL_CHK, S_DEL_WR,
    S_RD_ISS, S_RD_DATA,
    S_MOD, S_ROT, S_ROT_T, S_ROT_CHK, S_ROT_WR,
    S_POP, S_POP_D, S_PIV_D, S_P_CHK, S_P_CMP, S_P_SWJ, S_P_SWI,
    S_P_FIN, S_P_FIN2, S_PUSH1, S_PUSH2, S_SORT_DONE,
    S_F_FIRST, S_F_CHK, S_F_CMP
  } state_e;

  state_e              state_q, ret_q;
  logic [2:0]          mode_q;
  pas_pkg::elem_t      val_q, pivot_q, tmp_q, prev_q;
  logic [5:0]          pos_q, n_q;
  pas_pkg::count_t     cnt_q, k_q, sp_q, run_q;
  pas_pkg::addr_t      lo_q, hi_q, i_q, j_q;

  logic [1:0]          rst_st_q;
  pas_pkg::elem_t      res_el_q;
  logic [5:0]          res_ta_q;
  logic                res_last_q;

  logic                out_v_q;
  logic [1:0]          out_st_q;
  pas_pkg::elem_t      out_el_q;
  logic [5:0]          out_ta_q;
  logic                out_last_q;

  // element RAM
  logic                mem_we;
  pas_pkg::addr_t      mem_waddr, mem_raddr;
  pas_pkg::elem_t      mem_wdata, mem_rdata;
  // range stack RAM
  logic                stk_we;
  pas_pkg::addr_t      stk_waddr, stk_raddr;
  pas_pkg::span_t      stk_wdata, stk_rdata;

  pas_ram #(.WIDTH(pas_pkg::ElemBits), .DEPTH(pas_pkg::Capacity)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pas_ram #(.WIDTH(pas_pkg::StackBits), .DEPTH(pas_pkg::Capacity)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  logic                cnt_lt_cap, push1_ok, push2_ok;
  pas_pkg::count_t     last_idx;
  pas_pkg::addr_t      piv_p;

  assign cnt_lt_cap = sp_q < pas_pkg::count_t'(pas_pkg::Capacity);
  assign last_idx   = cnt_q - pas_pkg::count_t'(1);
  assign piv_p      = j_q;
  assign push1_ok   = ({1'b0, piv_p} > ({1'b0, lo_q} + 6'd1)) && cnt_lt_cap;
  assign push2_ok   = (({1'b0, piv_p} + 6'd1) < {1'b0, hi_q});

  assign cmd_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = out_v_q;
  assign res_o.status  = out_st_q;
  assign res_o.element = out_el_q;
  assign res_o.tally   = out_ta_q;
  assign res_o.last    = out_last_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = tmp_q;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = sp_q[pas_pkg::AddrBits-1:0];
    stk_wdata = '{lo: lo_q, hi: pas_pkg::addr_t'(piv_p - 1'b1)};
    stk_raddr = pas_pkg::addr_t'(sp_q - pas_pkg::count_t'(1));
    unique case (state_q)
      S_INS_CHK: begin
        if (k_q >= pas_pkg::count_t'(pos_q)) begin
          mem_raddr = pas_pkg::addr_t'(k_q - pas_pkg::count_t'(1));
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pas_pkg::addr_t'(pos_q - 6'd1);
          mem_wdata = val_q;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[pas_pkg::AddrBits-1:0];
        mem_wdata = mem_rdata;
      end
      S_DEL_CHK: mem_raddr = k_q[pas_pkg::AddrBits-1:0];
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pas_pkg::addr_t'(k_q - pas_pkg::count_t'(1));
        mem_wdata = mem_rdata;
      end
      S_RD_ISS: mem_raddr = pas_pkg::addr_t'(pos_q - 6'd1);
      S_ROT: begin
        mem_raddr = (mode_q == pas_pkg::MODE_ROR) ? last_idx[pas_pkg::AddrBits-1:0] : '0;
      end
      S_ROT_CHK: begin
        if (mode_q == pas_pkg::MODE_ROR) begin
          if (k_q != '0) begin
            mem_raddr = pas_pkg::addr_t'(k_q - pas_pkg::count_t'(1));
          end else begin
            mem_we    = 1'b1;
            mem_waddr = '0;
          end
        end else begin
          if ((k_q + pas_pkg::count_t'(1)) < cnt_q) begin
            mem_raddr = pas_pkg::addr_t'(k_q + pas_pkg::count_t'(1));
          end else begin
            mem_we    = 1'b1;
            mem_waddr = last_idx[pas_pkg::AddrBits-1:0];
          end
        end
      end
      S_ROT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[pas_pkg::AddrBits-1:0];
        mem_wdata = mem_rdata;
      end
      S_POP_D: mem_raddr = stk_rdata.hi;
      S_P_CHK: mem_raddr = (i_q < hi_q) ? i_q : j_q;
      S_P_CMP: mem_raddr = j_q;
      S_P_SWJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
      end
      S_P_SWI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
      end
      S_P_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = pivot_q;
      end
      S_P_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
      end
      S_PUSH1: stk_we = push1_ok;
      S_PUSH2: begin
        stk_we    = push2_ok && cnt_lt_cap;
        stk_wdata = '{lo: pas_pkg::addr_t'(piv_p + 1'b1), hi: hi_q};
      end
      S_SORT_DONE: mem_raddr = '0;
      S_F_CHK: mem_raddr = k_q[pas_pkg::AddrBits-1:0];
      S_IDLE: begin
        // initial range for a sort: (0, count-1)
        stk_we    = cmd_i.valid && (cnt_q >= pas_pkg::count_t'(2)) &&
                    ((cmd_i.mode == pas_pkg::MODE_SORT) || (cmd_i.mode == pas_pkg::MODE_FREQ));
        stk_waddr = '0;
        stk_wdata = '{lo: '0, hi: last_idx[pas_pkg::AddrBits-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      cnt_q      <= '0;
      sp_q       <= '0;
      out_v_q    <= 1'b0;
      mode_q     <= '0;
      val_q      <= '0;
      pos_q      <= '0;
      n_q        <= '0;
      k_q        <= '0;
      run_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      i_q        <= '0;
      j_q        <= '0;
      pivot_q    <= '0;
      tmp_q      <= '0;
      prev_q     <= '0;
      rst_st_q   <= '0;
      res_el_q   <= '0;
      res_ta_q   <= '0;
      res_last_q <= 1'b0;
      out_st_q   <= '0;
      out_el_q   <= '0;
      out_ta_q   <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_v_q && res_o.ready && (state_q != S_EMIT)) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            mode_q     <= cmd_i.mode;
            val_q      <= cmd_i.value;
            pos_q      <= cmd_i.position;
            n_q        <= cmd_i.position;
            rst_st_q   <= pas_pkg::ST_OK;
            res_el_q   <= '0;
            res_ta_q   <= 6'(cnt_q);
            res_last_q <= 1'b1;
            ret_q      <= S_IDLE;
            state_q    <= S_EMIT;
            unique case (cmd_i.mode)
              pas_pkg::MODE_INSERT: begin
                if (cnt_q >= pas_pkg::count_t'(pas_pkg::Capacity)) begin
                  rst_st_q <= pas_pkg::ST_FULL;
                end else if (cmd_i.position == '0 ||
                             7'(cmd_i.position) > (7'(cnt_q) + 7'd1)) begin
                  rst_st_q <= pas_pkg::ST_OOB;
                end else begin
                  k_q     <= cnt_q;
                  state_q <= S_INS_CHK;
                end
              end
              pas_pkg::MODE_DELETE, pas_pkg::MODE_READ: begin
                if (cnt_q == '0) begin
                  rst_st_q <= pas_pkg::ST_EMPTY;
                end else if (cmd_i.position == '0 || 7'(cmd_i.position) > 7'(cnt_q)) begin
                  rst_st_q <= pas_pkg::ST_OOB;
                end else if (cmd_i.mode == pas_pkg::MODE_DELETE) begin
                  k_q     <= pas_pkg::count_t'(cmd_i.position);
                  state_q <= S_DEL_CHK;
                end else begin
                  state_q <= S_RD_ISS;
                end
              end
              pas_pkg::MODE_ROR, pas_pkg::MODE_ROL: begin
                if (cnt_q == '0) begin
                  rst_st_q <= pas_pkg::ST_EMPTY;
                end else begin
                  state_q <= S_MOD;
                end
              end
              pas_pkg::MODE_SORT, pas_pkg::MODE_FREQ: begin
                if (cmd_i.mode == pas_pkg::MODE_FREQ && cnt_q == '0) begin
                  rst_st_q <= pas_pkg::ST_EMPTY;
                end else if (cnt_q >= pas_pkg::count_t'(2)) begin
                  sp_q    <= pas_pkg::count_t'(1);
                  state_q <= S_POP;
                end else begin
                  state_q <= S_SORT_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (!out_v_q || res_o.ready) begin
            out_v_q    <= 1'b1;
            out_st_q   <= rst_st_q;
            out_el_q   <= res_el_q;
            out_ta_q   <= res_ta_q;
            out_last_q <= res_last_q;
            state_q    <= ret_q;
          end
        end
        S_INS_CHK: begin
          if (k_q >= pas_pkg::count_t'(pos_q)) begin
            state_q <= S_INS_WR;
          end else begin
            cnt_q    <= cnt_q + pas_pkg::count_t'(1);
            res_ta_q <= 6'(cnt_q + pas_pkg::count_t'(1));
            state_q  <= S_EMIT;
          end
        end
        S_INS_WR: begin
          k_q     <= k_q - pas_pkg::count_t'(1);
          state_q <= S_INS_CHK;
        end
        S_DEL_CHK: begin
          if (k_q < cnt_q) begin
            state_q <= S_DEL_WR;
          end else begin
            cnt_q    <= last_idx;
            res_ta_q <= 6'(last_idx);
            state_q  <= S_EMIT;
          end
        end
        S_DEL_WR: begin
          k_q     <= k_q + pas_pkg::count_t'(1);
          state_q <= S_DEL_CHK;
        end
        S_RD_ISS: state_q <= S_RD_DATA;
        S_RD_DATA: begin
          res_el_q <= mem_rdata;
          state_q  <= S_EMIT;
        end
        // count modulo occupancy by repeated subtraction
        S_MOD: begin
          if (n_q >= 6'(cnt_q)) begin
            n_q <= n_q - 6'(cnt_q);
          end else begin
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (n_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            n_q     <= n_q - 6'd1;
            state_q <= S_ROT_T;
          end
        end
        S_ROT_T: begin
          tmp_q   <= mem_rdata;
          k_q     <= (mode_q == pas_pkg::MODE_ROR) ? last_idx : '0;
          state_q <= S_ROT_CHK;
        end
        S_ROT_CHK: begin
          if (mode_q == pas_pkg::MODE_ROR) begin
            state_q <= (k_q != '0) ? S_ROT_WR : S_ROT;
          end else begin
            state_q <= ((k_q + pas_pkg::count_t'(1)) < cnt_q) ? S_ROT_WR : S_ROT;
          end
        end
        S_ROT_WR: begin
          k_q     <= (mode_q == pas_pkg::MODE_ROR) ? k_q - pas_pkg::count_t'(1)
                                                  : k_q + pas_pkg::count_t'(1);
          state_q <= S_ROT_CHK;
        end
        S_POP: begin
          if (sp_q == '0) begin
            state_q <= S_SORT_DONE;
          end else begin
            sp_q    <= sp_q - pas_pkg::count_t'(1);
            state_q <= S_POP_D;
          end
        end
        S_POP_D: begin
          lo_q    <= stk_rdata.lo;
          hi_q    <= stk_rdata.hi;
          i_q     <= stk_rdata.lo;
          j_q     <= stk_rdata.lo;
          state_q <= S_PIV_D;
        end
        S_PIV_D: begin
          pivot_q <= mem_rdata;
          state_q <= S_P_CHK;
        end
        S_P_CHK: state_q <= (i_q < hi_q) ? S_P_CMP : S_P_FIN;
        S_P_CMP: begin
          if ($signed(mem_rdata) < $signed(pivot_q)) begin
            tmp_q   <= mem_rdata;
            state_q <= S_P_SWJ;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_P_CHK;
          end
        end
        S_P_SWJ: begin
          tmp_q   <= mem_rdata;
          state_q <= S_P_SWI;
        end
        S_P_SWI: begin
          i_q     <= i_q + 1'b1;
          j_q     <= j_q + 1'b1;
          state_q <= S_P_CHK;
        end
        S_P_FIN: begin
          tmp_q   <= mem_rdata;
          state_q <= S_P_FIN2;
        end
        S_P_FIN2: state_q <= S_PUSH1;
        S_PUSH1: begin
          if (push1_ok) begin
            sp_q <= sp_q + pas_pkg::count_t'(1);
          end
          state_q <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push2_ok && cnt_lt_cap) begin
            sp_q <= sp_q + pas_pkg::count_t'(1);
          end
          state_q <= S_POP;
        end
        S_SORT_DONE: begin
          if (mode_q == pas_pkg::MODE_FREQ) begin
            k_q     <= pas_pkg::count_t'(1);
            state_q <= S_F_FIRST;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_F_FIRST: begin
          prev_q  <= mem_rdata;
          run_q   <= pas_pkg::count_t'(1);
          state_q <= S_F_CHK;
        end
        S_F_CHK: begin
          if (k_q < cnt_q) begin
            state_q <= S_F_CMP;
          end else begin
            res_el_q   <= prev_q;
            res_ta_q   <= 6'(run_q);
            res_last_q <= 1'b1;
            ret_q      <= S_IDLE;
            state_q    <= S_EMIT;
          end
        end
        S_F_CMP: begin
          k_q <= k_q + pas_pkg::count_t'(1);
          if (mem_rdata == prev_q) begin
            run_q   <= run_q + pas_pkg::count_t'(1);
            state_q <= S_F_CHK;
          end else begin
            res_el_q   <= prev_q;
            res_ta_q   <= 6'(run_q);
            res_last_q <= 1'b0;
            prev_q     <= mem_rdata;
            run_q      <= pas_pkg::count_t'(1);
            ret_q      <= S_F_CHK;
            state_q    <= S_EMIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
